@@ hdl/cdq_pkg.sv @@
package cdq_pkg;

  localparam int WORD_W = 32;
  localparam int OP_W   = 2;
  localparam int STS_W  = 2;
  localparam int CFG_W  = 8;

  // Request codes.
  localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_INS_REAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_REM_FRONT = 2'd2;
  localparam logic [OP_W-1:0] OP_REM_REAR  = 2'd3;

  // Result status codes.
  localparam logic [STS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STS_W-1:0] STS_OVERFLOW  = 2'd1;
  localparam logic [STS_W-1:0] STS_UNDERFLOW = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_READ = 4'b0100,
    ST_DONE = 4'b1000
  } cdq_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic exec;
    logic rd;
    logic load;
  } cdq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } cdq_sts_t;

endpackage

@@ hdl/cdq_req_if.sv @@
interface cdq_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::OP_W-1:0]             op;
  logic signed [cdq_pkg::WORD_W-1:0]    data_word;

  modport source (output valid, output op, output data_word, input ready);
  modport sink   (input valid, input op, input data_word, output ready);
endinterface

@@ hdl/cdq_rsp_if.sv @@
interface cdq_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [cdq_pkg::STS_W-1:0]            status;
  logic signed [cdq_pkg::WORD_W-1:0]    front_word;
  logic signed [cdq_pkg::WORD_W-1:0]    rear_word;
  logic                                 is_empty;
  logic                                 is_full;

  modport source (output valid, output status, output front_word, output rear_word,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input front_word, input rear_word,
                  input is_empty, input is_full, output ready);
endinterface

@@ hdl/cdq_ctrl.sv @@
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cdq_pkg::cdq_sts_t sts,
  output cdq_pkg::cdq_cmd_t cmd
);

  cdq_pkg::cdq_state_t state_r, state_nxt;
  logic                accept;

  assign in_ready = (state_r == cdq_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd         = '0;
    cmd.capture = accept;
    cmd.exec    = (state_r == cdq_pkg::ST_EXEC);
    cmd.rd      = (state_r == cdq_pkg::ST_READ);
    cmd.load    = (state_r == cdq_pkg::ST_DONE) && sts.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdq_pkg::ST_IDLE: begin
        if (accept) state_nxt = cdq_pkg::ST_EXEC;
      end
      cdq_pkg::ST_EXEC: state_nxt = cdq_pkg::ST_READ;
      cdq_pkg::ST_READ: state_nxt = cdq_pkg::ST_DONE;
      cdq_pkg::ST_DONE: begin
        if (sts.out_free) state_nxt = cdq_pkg::ST_IDLE;
      end
      default: state_nxt = cdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cdq_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == cdq_pkg::ST_EXEC)
    else $error("accepted word did not start execution");

  a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == cdq_pkg::ST_IDLE && in_ready)
    else $error("controller did not return to idle after loading a result");
`endif

endmodule

@@ hdl/cdq_dpath.sv @@
module cdq_dpath #(
  parameter int DEPTH = 128
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  cdq_pkg::cdq_cmd_t                  cmd,
  output cdq_pkg::cdq_sts_t                  sts,
  input  logic                               cfg_we,
  input  logic [cdq_pkg::CFG_W-1:0]          cfg_data,
  input  logic [cdq_pkg::OP_W-1:0]           in_op,
  input  logic signed [cdq_pkg::WORD_W-1:0]  in_data_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [cdq_pkg::STS_W-1:0]          out_status,
  output logic signed [cdq_pkg::WORD_W-1:0]  out_front_word,
  output logic signed [cdq_pkg::WORD_W-1:0]  out_rear_word,
  output logic                               out_is_empty,
  output logic                               out_is_full
);

  localparam int IW = $clog2(DEPTH);
  localparam int NW = IW + 1;
  localparam int CW = (NW > cdq_pkg::CFG_W) ? NW : cdq_pkg::CFG_W;

  logic [CW-1:0]                     cap_r;
  logic [NW-1:0]                     used_n;
  logic [IW-1:0]                     last_idx;

  logic [IW-1:0]                     head_r, head_nxt, tail_r, tail_nxt;
  logic                              empty_r, empty_nxt;
  logic [cdq_pkg::STS_W-1:0]         status_r, status_nxt;
  logic [cdq_pkg::OP_W-1:0]          op_r;
  logic [cdq_pkg::WORD_W-1:0]        word_r;

  logic [IW-1:0]                     head_inc, head_dec, tail_inc, tail_dec;
  logic                              full_now;
  logic                              wr_en;
  logic [IW-1:0]                     wr_addr;

  logic [cdq_pkg::WORD_W-1:0]        ring_mem [DEPTH];
  logic [cdq_pkg::WORD_W-1:0]        rd_front_r, rd_rear_r;

  logic                              out_valid_r;
  logic [cdq_pkg::STS_W-1:0]         out_status_r;
  logic [cdq_pkg::WORD_W-1:0]        out_front_r, out_rear_r;
  logic                              out_empty_r, out_full_r;

  // Ring size in use: the register clamped to 1..DEPTH.
  always_comb begin
    if (cap_r == '0) begin
      used_n = NW'(1);
    end else if (cap_r > CW'(DEPTH)) begin
      used_n = NW'(DEPTH);
    end else begin
      used_n = NW'(cap_r);
    end
    last_idx = IW'(used_n - NW'(1));
  end

  assign head_inc = (head_r == last_idx) ? '0 : head_r + IW'(1);
  assign head_dec = (head_r == '0) ? last_idx : head_r - IW'(1);
  assign tail_inc = (tail_r == last_idx) ? '0 : tail_r + IW'(1);
  assign tail_dec = (tail_r == '0) ? last_idx : tail_r - IW'(1);
  assign full_now = !empty_r && (tail_inc == head_r);

  always_comb begin
    head_nxt   = head_r;
    tail_nxt   = tail_r;
    empty_nxt  = empty_r;
    status_nxt = status_r;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    if (cfg_we) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (cmd.exec) begin
      status_nxt = cdq_pkg::STS_OK;
      case (op_r)
        cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR: begin
          if (full_now) begin
            status_nxt = cdq_pkg::STS_OVERFLOW;
          end else begin
            wr_en     = 1'b1;
            empty_nxt = 1'b0;
            if (empty_r) begin
              head_nxt = '0;
              tail_nxt = '0;
              wr_addr  = '0;
            end else if (op_r == cdq_pkg::OP_INS_FRONT) begin
              head_nxt = head_dec;
              wr_addr  = head_dec;
            end else begin
              tail_nxt = tail_inc;
              wr_addr  = tail_inc;
            end
          end
        end
        cdq_pkg::OP_REM_FRONT, cdq_pkg::OP_REM_REAR: begin
          if (empty_r) begin
            status_nxt = cdq_pkg::STS_UNDERFLOW;
          end else if (head_r == tail_r) begin
            empty_nxt = 1'b1;
            head_nxt  = '0;
            tail_nxt  = '0;
          end else if (op_r == cdq_pkg::OP_REM_FRONT) begin
            head_nxt = head_inc;
          end else begin
            tail_nxt = tail_dec;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= CW'(DEPTH);
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else begin
      if (cfg_we) cap_r <= CW'(cfg_data);
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    if (cmd.capture) begin
      op_r   <= in_op;
      word_r <= in_data_word;
    end
  end

  // Ring storage: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (wr_en) ring_mem[wr_addr] <= word_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rd_front_r <= ring_mem[head_r];
      rd_rear_r  <= ring_mem[tail_r];
    end
  end

  // Output register.
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_status_r <= status_r;
      out_front_r  <= empty_r ? '1 : rd_front_r;
      out_rear_r   <= empty_r ? '1 : rd_rear_r;
      out_empty_r  <= empty_r;
      out_full_r   <= full_now;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_front_word = out_front_r;
  assign out_rear_word  = out_rear_r;
  assign out_is_empty   = out_empty_r;
  assign out_is_full    = out_full_r;

`ifndef SYNTHESIS
  a_empty_indices: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> head_r == '0 && tail_r == '0)
    else $error("empty deque with nonzero indices");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= last_idx && tail_r <= last_idx)
    else $error("ring index beyond capacity in use");
`endif

endmodule

@@ hdl/circular_deque_top.sv @@
// Each accepted word passes through the accept, update, memory read and output load steps
// of the controller, and a new word is not accepted until the last one has been loaded into
// the result register; the load waits while the previous result has not been taken.
// The input side reopens while a result still waits in the output register.
// Reset (rst_n, synchronous, active low) empties the deque and sets capacity to DEPTH;
// ring contents are not cleared.
module circular_deque_top #(
  parameter int DEPTH = 128
) (
  input  logic                       clk,
  input  logic                       rst_n,
  cdq_req_if.sink                    in_ch,
  cdq_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [cdq_pkg::CFG_W-1:0]  cfg_data
);

  // The controller sequences each word through four steps: accept, update the
  // indices and write the ring, read the front and rear entries, and load the
  // result register. The datapath holds the ring, the indices, the capacity
  // register and the result register.
  cdq_pkg::cdq_cmd_t cmd;
  cdq_pkg::cdq_sts_t sts;

  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // A capacity write also empties the deque; users issue it only while idle, unchecked.
  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .in_op          (in_ch.op),
    .in_data_word   (in_ch.data_word),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_status     (out_ch.status),
    .out_front_word (out_ch.front_word),
    .out_rear_word  (out_ch.rear_word),
    .out_is_empty   (out_ch.is_empty),
    .out_is_full    (out_ch.is_full)
  );

endmodule

@@ tb/sv/tb_circular_deque_top.sv @@
module tb_circular_deque_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 128;
  // Longest normal quiet stretch is a sender gap, the block's steps and a
  // receiver stall, so a much longer stretch without a handshake means a hang.
  localparam int IDLE_LIMIT = 400;

  // One predicted snapshot of the deque, as the result port reports it.
  typedef struct {
    logic [cdq_pkg::STS_W-1:0]  status;
    logic [cdq_pkg::WORD_W-1:0] front_word;
    logic [cdq_pkg::WORD_W-1:0] rear_word;
    logic                       is_empty;
    logic                       is_full;
  } deque_view_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [cdq_pkg::CFG_W-1:0] cfg_data;

  cdq_req_if req_ch();
  cdq_rsp_if rsp_ch();

  circular_deque_top #(.DEPTH(DEPTH)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Mirror of the deque: ring contents, both ends, the empty flag and the
  // capacity register exactly as last written (clamping happens on use).
  logic [cdq_pkg::WORD_W-1:0] ring_mirror [0:DEPTH-1];
  int                         front_pos;
  int                         rear_pos;
  bit                         mirror_empty;
  logic [cdq_pkg::CFG_W-1:0]  cap_setting;

  // Snapshots predicted for accepted requests, oldest first.
  deque_view_t predicted_views [$];

  // When set, neither side inserts idle cycles, giving back-to-back traffic.
  bit steady;

  int mismatches;
  int words_sent;
  int results_checked;
  int overflow_seen;
  int underflow_seen;
  int cfg_writes;
  int stalled_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Capacity in effect: zero behaves as one, anything above the ring depth
  // behaves as the ring depth.
  function automatic int ring_size();
    if (cap_setting == 0) return 1;
    if (cap_setting > DEPTH) return DEPTH;
    return int'(cap_setting);
  endfunction

  function automatic bit mirror_full();
    int next_rear;
    next_rear = (rear_pos + 1 >= ring_size()) ? 0 : rear_pos + 1;
    return !mirror_empty && next_rear == front_pos;
  endfunction

  // Applies one request to the mirror and returns the snapshot that the
  // block must report for it.
  function automatic deque_view_t apply_request(logic [cdq_pkg::OP_W-1:0] op,
                                                logic [cdq_pkg::WORD_W-1:0] word);
    deque_view_t view;
    int          n;
    n = ring_size();
    view.status = cdq_pkg::STS_OK;
    if (op inside {cdq_pkg::OP_INS_FRONT, cdq_pkg::OP_INS_REAR}) begin
      if (mirror_full()) begin
        view.status = cdq_pkg::STS_OVERFLOW;
        overflow_seen++;
      end else begin
        if (mirror_empty) begin
          // The first word always lands in slot zero.
          front_pos = 0;
          rear_pos  = 0;
          ring_mirror[0] = word;
        end else if (op == cdq_pkg::OP_INS_FRONT) begin
          front_pos = (front_pos == 0) ? n - 1 : front_pos - 1;
          ring_mirror[front_pos] = word;
        end else begin
          rear_pos = (rear_pos + 1 >= n) ? 0 : rear_pos + 1;
          ring_mirror[rear_pos] = word;
        end
        mirror_empty = 1'b0;
      end
    end else begin
      if (mirror_empty) begin
        view.status = cdq_pkg::STS_UNDERFLOW;
        underflow_seen++;
      end else if (front_pos == rear_pos) begin
        // Taking the last word sends both ends back to slot zero.
        mirror_empty = 1'b1;
        front_pos    = 0;
        rear_pos     = 0;
      end else if (op == cdq_pkg::OP_REM_FRONT) begin
        front_pos = (front_pos + 1 >= n) ? 0 : front_pos + 1;
      end else begin
        rear_pos = (rear_pos == 0) ? n - 1 : rear_pos - 1;
      end
    end
    view.front_word = mirror_empty ? '1 : ring_mirror[front_pos];
    view.rear_word  = mirror_empty ? '1 : ring_mirror[rear_pos];
    view.is_empty   = mirror_empty;
    view.is_full    = mirror_full();
    return view;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("ERROR at %0t, result %0d, %s: got %h, expected %h",
             $realtime, results_checked, field, got, want);
    mismatches++;
  endtask

  // Offers one request word after a random gap, holds it until the block
  // takes it, and records the predicted result at that edge. Entered and
  // left at a falling edge.
  task automatic send_word(logic [cdq_pkg::OP_W-1:0] op, logic [cdq_pkg::WORD_W-1:0] word);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.op        <= op;
    req_ch.data_word <= word;
    do @(posedge clk); while (!req_ch.ready);
    predicted_views.push_back(apply_request(op, word));
    words_sent++;
    @(negedge clk);
  endtask

  // Stops offering words until every outstanding result has come back.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    while (predicted_views.size() != 0) @(negedge clk);
  endtask

  // The capacity register is only written with the block idle. The write
  // also empties the deque, so the mirror is cleared along with it.
  task automatic write_capacity(logic [cdq_pkg::CFG_W-1:0] value);
    hold_until_drained();
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we       <= 1'b0;
    cap_setting  = value;
    front_pos    = 0;
    rear_pos     = 0;
    mirror_empty = 1'b1;
    cfg_writes++;
  endtask

  // Removals from the deque as it comes out of reset must underflow and
  // report both ends as all ones.
  task automatic test_empty_removals();
    send_word(cdq_pkg::OP_REM_FRONT, 32'h1234_5678);
    send_word(cdq_pkg::OP_REM_REAR, 32'hFFFF_FFFF);
  endtask

  // Inserts at both ends with the extreme words, then removes from both
  // ends down to the last word and one more.
  task automatic test_both_ends();
    send_word(cdq_pkg::OP_INS_FRONT, 32'h8000_0000);
    send_word(cdq_pkg::OP_INS_REAR, 32'h7FFF_FFFF);
    send_word(cdq_pkg::OP_INS_FRONT, 32'hFFFF_FFFF);
    send_word(cdq_pkg::OP_INS_REAR, 32'h0000_0000);
    send_word(cdq_pkg::OP_REM_FRONT, 32'h0000_0000);
    send_word(cdq_pkg::OP_REM_REAR, 32'hFFFF_FFFF);
    send_word(cdq_pkg::OP_REM_REAR, 32'h0000_0000);
    send_word(cdq_pkg::OP_REM_FRONT, 32'h0000_0000);
    send_word(cdq_pkg::OP_REM_FRONT, 32'h0000_0000);
  endtask

  // A capacity of zero acts as one: a single word fills the deque and
  // every further insert overflows. A capacity of two wraps the front end.
  task automatic test_capacity_edges();
    write_capacity(8'd0);
    send_word(cdq_pkg::OP_INS_REAR, 32'hA5A5_A5A5);
    send_word(cdq_pkg::OP_INS_FRONT, 32'h5A5A_5A5A);
    send_word(cdq_pkg::OP_INS_REAR, 32'h0F0F_0F0F);
    send_word(cdq_pkg::OP_REM_REAR, 32'h0000_0000);
    send_word(cdq_pkg::OP_REM_FRONT, 32'h0000_0000);
    write_capacity(8'd2);
    send_word(cdq_pkg::OP_INS_REAR, 32'h1111_1111);
    send_word(cdq_pkg::OP_INS_FRONT, 32'h2222_2222);
    send_word(cdq_pkg::OP_INS_REAR, 32'h3333_3333);
    send_word(cdq_pkg::OP_REM_FRONT, 32'h0000_0000);
    send_word(cdq_pkg::OP_INS_REAR, 32'h4444_4444);
    send_word(cdq_pkg::OP_REM_REAR, 32'h0000_0000);
  endtask

  // A capacity write empties a deque that still holds a word, and a value
  // above the ring depth acts as the ring depth.
  task automatic test_config_clears();
    write_capacity(8'd255);
    send_word(cdq_pkg::OP_REM_FRONT, 32'h0000_0000);
  endtask

  // Random traffic over a range of capacities. Each phase swings between
  // filling and draining so that the deque reaches full and empty often
  // and tries to overflow and underflow there.
  task automatic test_random_traffic();
    int                         caps [12];
    int                         count;
    bit                         filling;
    logic [cdq_pkg::OP_W-1:0]   op;
    logic [cdq_pkg::WORD_W-1:0] word;
    caps = '{5, 128, 0, 1, 2, 255, 9, 33, 200, 3, 17, 129};
    for (int p = 0; p < 12; p++) begin
      steady = (p == 2 || p == 7);
      write_capacity(caps[p][cdq_pkg::CFG_W-1:0]);
      count   = (ring_size() >= 100) ? 170 : 55;
      filling = 1'b1;
      for (int i = 0; i < count; i++) begin
        // Once in the run, let everything outstanding drain mid-phase.
        if (p == 5 && i == count / 2) hold_until_drained();
        if ($urandom_range(0, 99) < (filling ? 80 : 20))
          op = $urandom_range(0, 1) ? cdq_pkg::OP_INS_REAR : cdq_pkg::OP_INS_FRONT;
        else
          op = $urandom_range(0, 1) ? cdq_pkg::OP_REM_REAR : cdq_pkg::OP_REM_FRONT;
        case ($urandom_range(0, 15))
          0:       word = 32'h8000_0000;
          1:       word = 32'h7FFF_FFFF;
          2:       word = 32'hFFFF_FFFF;
          3:       word = 32'h0000_0000;
          default: word = $urandom;
        endcase
        send_word(op, word);
        if (mirror_full() && $urandom_range(0, 2) == 0) filling = 1'b0;
        else if (mirror_empty && $urandom_range(0, 2) == 0) filling = 1'b1;
        else if ($urandom_range(0, 39) == 0) filling = !filling;
      end
    end
    steady = 1'b0;
  endtask

  // Result side: draws a stall before each result, then takes the next
  // word and compares every field with the oldest prediction.
  initial begin
    int          stall;
    deque_view_t want;
    rsp_ch.ready = 1'b0;
    do @(negedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      results_checked++;
      if (predicted_views.size() == 0) begin
        report_mismatch("no result expected, front_word", rsp_ch.front_word, '0);
      end else begin
        want = predicted_views.pop_front();
        if (rsp_ch.status !== want.status)
          report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
        if (rsp_ch.front_word !== want.front_word)
          report_mismatch("front_word", rsp_ch.front_word, want.front_word);
        if (rsp_ch.rear_word !== want.rear_word)
          report_mismatch("rear_word", rsp_ch.rear_word, want.rear_word);
        if (rsp_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", 32'(rsp_ch.is_empty), 32'(want.is_empty));
        if (rsp_ch.is_full !== want.is_full)
          report_mismatch("is_full", 32'(rsp_ch.is_full), 32'(want.is_full));
      end
      @(negedge clk);
    end
  end

  // Watchdog: any handshake or register write counts as progress.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (req_ch.valid && req_ch.ready) ||
        (rsp_ch.valid && rsp_ch.ready)) begin
      stalled_cycles = 0;
    end else begin
      stalled_cycles++;
    end
    if (stalled_cycles >= IDLE_LIMIT) begin
      $display("Watchdog: no progress for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, predicted_views.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    req_ch.valid     = 1'b0;
    req_ch.op        = cdq_pkg::OP_INS_FRONT;
    req_ch.data_word = '0;
    steady           = 1'b0;
    // Reset leaves the deque empty with the capacity at the ring depth.
    cap_setting  = cdq_pkg::CFG_W'(DEPTH);
    front_pos    = 0;
    rear_pos     = 0;
    mirror_empty = 1'b1;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_removals();
    test_both_ends();
    test_capacity_edges();
    test_config_clears();
    test_random_traffic();

    // Let the last results come back, then watch a little longer for any
    // stray word on the result port.
    hold_until_drained();
    repeat (10) @(negedge clk);

    $display("Sent %0d request words over %0d capacity writes; checked %0d results.",
             words_sent, cfg_writes, results_checked);
    $display("Overflow predicted %0d times, underflow %0d times.",
             overflow_seen, underflow_seen);
    if (mismatches == 0 && predicted_views.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
